### hdl/bed_genotype_stream_decoder_unit_assert.svh
// assertion macros used by the checker
`ifndef BED_GENOTYPE_STREAM_DECODER_UNIT_ASSERT_SVH
`define BED_GENOTYPE_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define BGSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BGSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bgsd_pkg.sv
`timescale 1ns / 1ps
package bgsd_pkg;

  localparam int SAMPLE_W   = 21;
  localparam int SNP_W      = 25;
  localparam int BYTE_IDX_W = 18;
  localparam int FIRST_W    = 20;
  localparam int SNP_IDX_W  = 24;
  localparam int CFG_DATA_W = 25;
  localparam int OUT_DATA_W = 56;

  localparam logic [SAMPLE_W-1:0] MAX_SAMPLES = 21'h100000;
  localparam logic [SNP_W-1:0]    MAX_SNPS    = 25'h1000000;

  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_SNP_COUNT    = 1'b1;

  localparam logic STATUS_GENO     = 1'b0;
  localparam logic STATUS_MODE_ERR = 1'b1;

  localparam logic [1:0] HDR_MODE = 2'd2;
  localparam logic [1:0] HDR_DATA = 2'd3;

  localparam logic [7:0] MODE_IND_MAJOR = 8'h00;

  typedef struct packed {
    logic [BYTE_IDX_W-1:0] last_byte;
    logic [2:0]            last_valid;
    logic [SNP_W-1:0]      snp_limit;
  } cfg_eff_t;

  typedef struct packed {
    logic                 status;
    logic                 snp_last;
    logic [SNP_IDX_W-1:0] snp_index;
    logic [FIRST_W-1:0]   first_sample;
    logic [2:0]           valid_count;
    logic [1:0]           geno_d;
    logic [1:0]           geno_c;
    logic [1:0]           geno_b;
    logic [1:0]           geno_a;
  } out_item_t;

  function automatic logic [1:0] map_pair(input logic [1:0] pair);
    logic [1:0] g;
    unique case (pair)
      2'b11: g = 2'd0;
      2'b10: g = 2'd1;
      2'b00: g = 2'd2;
      default: g = 2'd3;
    endcase
    return g;
  endfunction

endpackage

### hdl/bgsd_cfg.sv
`timescale 1ns / 1ps
module bgsd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bgsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bgsd_pkg::cfg_eff_t             eff
);
  import bgsd_pkg::*;

  logic [SAMPLE_W-1:0] sample_count_r;
  logic [SNP_W-1:0]    snp_count_r;
  logic [FIRST_W-1:0]  n_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_W'(1);
      snp_count_r    <= SNP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_SNP_COUNT:    snp_count_r    <= cfg_wdata[SNP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sample count minus one, clamped to 1..MAX_SAMPLES
  always_comb begin
    priority if (sample_count_r == '0) begin
      n_m1 = '0;
    end else if (sample_count_r > MAX_SAMPLES) begin
      n_m1 = FIRST_W'(MAX_SAMPLES - SAMPLE_W'(1));
    end else begin
      n_m1 = FIRST_W'(sample_count_r - SAMPLE_W'(1));
    end
  end

  always_comb begin
    eff.last_byte  = n_m1[FIRST_W-1:2];
    eff.last_valid = {1'b0, n_m1[1:0]} + 3'd1;
    priority if (snp_count_r == '0) begin
      eff.snp_limit = SNP_W'(1);
    end else if (snp_count_r > MAX_SNPS) begin
      eff.snp_limit = MAX_SNPS;
    end else begin
      eff.snp_limit = snp_count_r;
    end
  end

endmodule

### hdl/bgsd_core.sv
`timescale 1ns / 1ps
module bgsd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_byte,
  input  bgsd_pkg::cfg_eff_t  eff,
  input  logic                out_free,
  output logic                res_valid,
  output bgsd_pkg::out_item_t res
);
  import bgsd_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic [1:0]            hdr_pos_r, hdr_pos_nxt;
  logic [BYTE_IDX_W-1:0] byte_in_snp_r, byte_in_snp_nxt;
  logic [SNP_W-1:0]      snp_cnt_r, snp_cnt_nxt;
  logic                  halted_r, halted_nxt;
  logic                  work;
  logic                  last;
  logic                  in_acc;

  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign work      = s1_valid_r && out_free;
  assign last      = byte_in_snp_r >= eff.last_byte;

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (work ? 1'b0 : s1_valid_r);
  end

  always_comb begin
    hdr_pos_nxt     = hdr_pos_r;
    byte_in_snp_nxt = byte_in_snp_r;
    snp_cnt_nxt     = snp_cnt_r;
    halted_nxt      = halted_r;
    res_valid       = 1'b0;
    res             = '0;
    if (work && !halted_r) begin
      priority if (hdr_pos_r < HDR_MODE) begin
        hdr_pos_nxt = hdr_pos_r + 2'd1;
      end else if (hdr_pos_r == HDR_MODE) begin
        hdr_pos_nxt = HDR_DATA;
        if (s1_byte_r == MODE_IND_MAJOR) begin
          halted_nxt = 1'b1;
          res_valid  = 1'b1;
          res.status = STATUS_MODE_ERR;
        end
      end else if (snp_cnt_r < eff.snp_limit) begin
        res_valid        = 1'b1;
        res.status       = STATUS_GENO;
        res.geno_a       = map_pair(s1_byte_r[1:0]);
        res.geno_b       = map_pair(s1_byte_r[3:2]);
        res.geno_c       = map_pair(s1_byte_r[5:4]);
        res.geno_d       = map_pair(s1_byte_r[7:6]);
        res.valid_count  = last ? eff.last_valid : 3'd4;
        res.first_sample = {byte_in_snp_r, 2'b00};
        res.snp_index    = snp_cnt_r[SNP_IDX_W-1:0];
        res.snp_last     = last;
        if (last) begin
          byte_in_snp_nxt = '0;
          snp_cnt_nxt     = snp_cnt_r + SNP_W'(1);
        end else begin
          byte_in_snp_nxt = byte_in_snp_r + BYTE_IDX_W'(1);
        end
      end else begin
        res_valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      hdr_pos_r     <= '0;
      byte_in_snp_r <= '0;
      snp_cnt_r     <= '0;
      halted_r      <= 1'b0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      byte_in_snp_r <= byte_in_snp_nxt;
      snp_cnt_r     <= snp_cnt_nxt;
      halted_r      <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
    end
  end

endmodule

### hdl/bed_genotype_stream_decoder_unit.sv
`timescale 1ns / 1ps
// channel  | direction | tdata (low bit up)                                      | side
// in_      | slave     | byte_value                                              | -
// out_     | master    | geno_a..d, valid_count, first_sample, snp_index, pad    | tlast snp_last, tuser status
// cfg_     | write     | index 0 sample_count, 1 snp_count                       | -
// one request per cycle sustained while out_tready stays high
// input register, then decode and counter update into the output register
// reset clears the header, byte, snp counters, halt flag and both valid flags
// out_tready low holds the output register; the input stage fills and then stalls
module bed_genotype_stream_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // byte_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // geno_a, geno_b, geno_c, geno_d, valid_count, first_sample, snp_index, zero pad
  output logic [bgsd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,  // snp_last
  output logic                              out_tuser,  // status
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bgsd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bgsd_pkg::*;

  cfg_eff_t  eff;
  out_item_t res;
  out_item_t out_r;
  logic      res_valid;
  logic      out_free;
  logic      out_valid_r;

  assign out_free = !out_valid_r || out_tready;

  bgsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .eff       (eff)
  );

  bgsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .eff       (eff),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.snp_index, out_r.first_sample, out_r.valid_count,
                       out_r.geno_d, out_r.geno_c, out_r.geno_b, out_r.geno_a};
  assign out_tlast  = out_r.snp_last;
  assign out_tuser  = out_r.status;

endmodule

### hdl/bgsd_checker.sv
`timescale 1ns / 1ps
`include "bed_genotype_stream_decoder_unit_assert.svh"
module bgsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bgsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);
  import bgsd_pkg::*;

  `BGSD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "output request changed while stalled")
  `BGSD_ASSERT_NOW(a_err_clean, out_tvalid && out_tuser == STATUS_MODE_ERR, out_tdata == '0 && !out_tlast, "mode error request carries data")
  `BGSD_ASSERT_NOW(a_valid_range, out_tvalid && out_tuser == STATUS_GENO, out_tdata[10:8] != 3'd0 && out_tdata[10:8] <= 3'd4, "valid count out of range")
  `BGSD_ASSERT_NOW(a_full_mid, out_tvalid && out_tuser == STATUS_GENO && !out_tlast, out_tdata[10:8] == 3'd4, "partial byte before snp end")
  `BGSD_ASSERT_NEXT(a_halt, out_tvalid && out_tready && out_tuser == STATUS_MODE_ERR, !out_tvalid, "request after mode error")

endmodule

bind bed_genotype_stream_decoder_unit bgsd_checker u_bgsd_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bgsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 600;
  localparam int LONG_HOLD   = 200;

  class geno_scoreboard;
    out_item_t             pending_genos[$];
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SNP_W-1:0]      snp_reg;
    logic [1:0]            header_pos;
    logic [BYTE_IDX_W-1:0] byte_pos;
    logic [SNP_W-1:0]      snps_done;
    bit                    halted;
    int                    errors;

    function new();
      sample_reg    = 1;
      snp_reg       = 1;
      header_pos    = 0;
      byte_pos      = 0;
      snps_done     = 0;
      halted        = 0;
      errors        = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_SAMPLE_COUNT) begin
        sample_reg = value[SAMPLE_W-1:0];
      end else begin
        snp_reg = value[SNP_W-1:0];
      end
    endfunction

    function logic [1:0] genotype(logic [1:0] pair);
      case (pair)
        2'b11: return 2'd0;
        2'b10: return 2'd1;
        2'b00: return 2'd2;
        default: return 2'd3;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      out_item_t   e;
      int unsigned n;
      int unsigned blocks;
      int unsigned snp_limit;
      bit          closes;
      if (halted) return;
      if (header_pos < HDR_MODE) begin
        header_pos++;
        return;
      end
      if (header_pos == HDR_MODE) begin
        header_pos = HDR_DATA;
        if (b == MODE_IND_MAJOR) begin
          halted = 1;
          e = '0;
          e.status = STATUS_MODE_ERR;
          pending_genos.push_back(e);
        end
        return;
      end
      snp_limit = (snp_reg == 0) ? 1 : (snp_reg > MAX_SNPS) ? MAX_SNPS : snp_reg;
      if (snps_done >= snp_limit) return;
      n = (sample_reg == 0) ? 1 : (sample_reg > MAX_SAMPLES) ? MAX_SAMPLES : sample_reg;
      blocks = (n + 3) / 4;
      closes = (byte_pos + 1 >= blocks);
      e.geno_a       = genotype(b[1:0]);
      e.geno_b       = genotype(b[3:2]);
      e.geno_c       = genotype(b[5:4]);
      e.geno_d       = genotype(b[7:6]);
      e.valid_count  = closes ? 3'(n - (blocks - 1) * 4) : 3'd4;
      e.first_sample = {byte_pos, 2'b00};
      e.snp_index    = snps_done[SNP_IDX_W-1:0];
      e.snp_last     = closes;
      e.status       = STATUS_GENO;
      pending_genos.push_back(e);
      if (closes) begin
        byte_pos = 0;
        snps_done++;
      end else begin
        byte_pos++;
      end
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last, logic user);
      out_item_t got;
      out_item_t want;
      got = {user, last, data[OUT_DATA_W-2:0]};
      if (pending_genos.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_genos.pop_front();
      report("geno_a", want.geno_a, got.geno_a);
      report("geno_b", want.geno_b, got.geno_b);
      report("geno_c", want.geno_c, got.geno_c);
      report("geno_d", want.geno_d, got.geno_d);
      report("valid_count", want.valid_count, got.valid_count);
      report("first_sample", want.first_sample, got.first_sample);
      report("snp_index", want.snp_index, got.snp_index);
      report("snp_last", want.snp_last, got.snp_last);
      report("status", want.status, got.status);
      report("pad", 0, data[OUT_DATA_W-1]);
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = CFG_SAMPLE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  geno_scoreboard genos;
  int unsigned    cycles      = 0;
  int             hold_asked  = 0;
  int             hold_served = 0;
  int             hold_left   = 0;
  int             stall_left  = 0;
  int             sent_bytes  = 0;

  bed_genotype_stream_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) genos.take_byte(in_tdata);
      if (out_tvalid && out_tready) genos.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // receiver: long hold on request, else random stalls outside calm stretches
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (cycles[9:8] < 2 && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
    gap = 0;
    if (!(cycles[9:8] == 1 || cycles[9:8] == 2) && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every pending genotype request has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (genos.pending_genos.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] samples, input logic [CFG_DATA_W-1:0] snps);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_wdata <= samples;
    @(posedge clk);
    genos.set_reg(CFG_SAMPLE_COUNT, samples);
    cfg_index <= CFG_SNP_COUNT;
    cfg_wdata <= snps;
    @(posedge clk);
    genos.set_reg(CFG_SNP_COUNT, snps);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit                    mode_fault;
    int                    pick;
    int                    n_len;
    int                    phase;
    logic [CFG_DATA_W-1:0] samp;
    logic [CFG_DATA_W-1:0] snps;
    genos = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    mode_fault = ($urandom_range(0, 3) == 0);

    // zero counts act as one
    write_regs(0, 0);
    // hold the mode error request so the input side backs up behind it
    if (mode_fault) hold_asked++;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mode_fault ? MODE_IND_MAJOR : 8'($urandom_range(1, 255)));

    if (mode_fault) begin
      // halted: nothing more comes out
      repeat (30) send_byte(8'($urandom_range(0, 255)));
      settle();
      write_regs(5, 25'h1FFFFFF);
      repeat (20) send_byte(8'($urandom_range(0, 255)));
      settle();
      write_regs(21'h1FFFFF, 3);
      while (sent_bytes < ITEM_TARGET) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'hE4);
      send_byte(8'h1B);
      settle();

      write_regs(5, genos.snps_done + 3);
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'hFF);
      send_byte(8'hE4);
      send_byte(8'h1B);
      send_byte(8'h99);
      settle();

      // saturated counts, then a shorter snp closes the open one
      write_regs(21'h1FFFFF, 25'h1FFFFFF);
      send_byte(8'h0F);
      send_byte(8'hF0);
      send_byte(8'h3C);
      settle();
      write_regs(4, 25'h1FFFFFF);
      send_byte(8'hC3);
      send_byte(8'h5A);
      settle();

      write_regs(MAX_SAMPLES, genos.snps_done + 2);
      send_byte(8'h12);
      send_byte(8'h34);
      settle();
      write_regs(7, genos.snps_done + 2);
      send_byte(8'h56);
      send_byte(8'h78);
      send_byte(8'h9A);
      settle();
      write_regs(6, genos.snps_done + 1);
      send_byte(8'hBC);
      send_byte(8'hDE);
      settle();

      phase = 0;
      while (sent_bytes < ITEM_TARGET) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) samp = $urandom_range(1, 16);
        else if (pick < 17) samp = $urandom_range(17, 300);
        else if (pick < 19) samp = 0;
        else samp = $urandom_range(1048570, 2097151);
        pick = $urandom_range(0, 9);
        if (pick < 7) snps = genos.snps_done + $urandom_range(1, 6);
        else if (pick == 7) snps = 25'h1FFFFFF;
        else if (pick == 8) snps = 0;
        else snps = genos.snps_done;
        if (phase == 3) begin
          samp = $urandom_range(1, 8);
          snps = genos.snps_done + 200;
        end
        write_regs(samp, snps);
        if (phase == 3) hold_asked++;
        n_len = $urandom_range(10, 50);
        repeat (n_len) send_byte(8'($urandom_range(0, 255)));
        settle();
        phase++;
      end
    end

    settle();
    if (genos.errors == 0 && genos.pending_genos.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/bgsd_pkg.sv
hdl/bgsd_cfg.sv
hdl/bgsd_core.sv
hdl/bed_genotype_stream_decoder_unit.sv
hdl/bgsd_checker.sv
tb/sv/testbench.sv
